/* rtl/core/mmor_pkg.sv */
`default_nettype none

package mmor_pkg;

  // Default capacity of the sample memory.
  localparam int unsigned MAX_SAMPLES_DEF = 1024;

  // Entries in the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Reset value of the cutoff register, 6.0 in unsigned Q8.8.
  localparam logic [15:0] SIGMA_RESET = 16'd1536;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               is_last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] median;
    logic        [31:0] mad;
    logic        [10:0] kept_count;
  } out_t;

  // Classified item that travels from the front to the back.
  typedef struct packed {
    logic signed [31:0] sample;
    logic               is_last;
    logic               store;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/mmor_front.sv */
`default_nettype none

module mmor_front #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  mmor_pkg::in_t    in_data,
  output logic             cmd_valid,
  input  wire              cmd_ready,
  output mmor_pkg::cmd_t   cmd_data
);
  import mmor_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  logic [CW-1:0] fill;
  logic          store;
  logic          xfer;

  // A sample is kept only while the memory has room.
  assign store    = fill < CW'(MAX_SAMPLES);
  assign in_ready = cmd_ready;
  assign cmd_valid = in_valid;
  assign xfer     = in_valid && cmd_ready;

  always_comb begin
    cmd_data.sample  = in_data.sample;
    cmd_data.is_last = in_data.is_last;
    cmd_data.store   = store;
  end

  // Count the samples of the current set; a closing item starts a new set.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (xfer) begin
      if (in_data.is_last) begin
        fill <= '0;
      end else if (store) begin
        fill <= fill + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mmor_queue.sv */
`default_nettype none

module mmor_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             push_valid,
  output logic            push_ready,
  input  mmor_pkg::cmd_t  push_data,
  output logic            pop_valid,
  input  wire             pop_ready,
  output mmor_pkg::cmd_t  pop_data
);
  import mmor_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   level;
  logic          do_push;
  logic          do_pop;

  assign push_ready = level < (PW+1)'(DEPTH);
  assign pop_valid  = level != '0;
  assign pop_data   = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  // Pointers wrap at the depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      level <= level + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= (PW+1)'(DEPTH))
    else $error("queue level beyond depth");
`endif

endmodule

`default_nettype wire

/* rtl/core/mmor_engine.sv */
`default_nettype none

module mmor_engine #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             cfg_we,
  input  wire [15:0]      cfg_wdata,
  input  wire             cmd_valid,
  output logic            cmd_ready,
  input  mmor_pkg::cmd_t  cmd_data,
  output logic            out_valid,
  input  wire             out_ready,
  output mmor_pkg::out_t  out_data
);
  import mmor_pkg::*;

  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SEL  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_REJ  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state;

  logic signed [31:0] mem [MAX_SAMPLES];
  logic signed [31:0] rd;
  logic               rv;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;

  logic [15:0]   sigma;
  logic [CW-1:0] lcnt;
  logic [CW-1:0] n_cur;
  logic [CW-1:0] cnt;
  logic [CW-1:0] k;
  logic [CW-1:0] c;
  logic [CW-1:0] kept;
  logic          removed;
  logic          phase_mad;
  logic [31:0]   prefix;
  logic [31:0]   sel_mask;
  logic [31:0]   hi_mask;
  logic signed [31:0] med;
  logic [31:0]   mad;
  logic [47:0]   thr;

  logic          pop;
  logic          scanning;
  logic          issue;
  logic          scan_done;
  logic [32:0]   diff;
  logic [31:0]   dev;
  logic [31:0]   key;
  logic          match;
  logic          reject;
  logic          bit_one;
  logic [31:0]   prefix_next;
  logic [CW-1:0] n_start;
  logic [CW:0]   rank_wide;
  logic [CW-1:0] rank_start;
  logic [CW:0]   rank_cur_wide;
  logic [CW-1:0] rank_cur;
  logic          start_pass;

  assign cmd_ready = state == ST_IDLE;
  assign pop       = cmd_valid && (state == ST_IDLE);
  assign scanning  = (state == ST_SEL) || (state == ST_REJ);
  assign issue     = scanning && (cnt < n_cur);
  assign scan_done = scanning && (cnt == n_cur) && !rv;
  assign raddr     = cnt[AW-1:0];

  // Absolute deviation of the word just read from the current median.
  always_comb begin
    diff = {rd[31], rd} - {med[31], med};
    dev  = diff[32] ? 32'(-diff) : diff[31:0];
  end

  // Radix selection key: samples in offset order, deviations as they are.
  assign key     = phase_mad ? dev : {~rd[31], rd[30:0]};
  assign match   = (((key ^ prefix) & hi_mask) == '0) && ((key & sel_mask) == '0);
  assign bit_one = k > c;
  assign prefix_next = bit_one ? (prefix | sel_mask) : prefix;
  assign reject  = {8'd0, dev, 8'd0} > thr;

  // Set size and rank at the start of a median pass.
  assign n_start       = (state == ST_IDLE) ? (lcnt + CW'(cmd_data.store)) : kept;
  assign rank_wide     = ((CW+1)'(n_start) + 1'b1) >> 1;
  assign rank_start    = rank_wide[CW-1:0];
  assign rank_cur_wide = ((CW+1)'(n_cur) + 1'b1) >> 1;
  assign rank_cur      = rank_cur_wide[CW-1:0];
  assign start_pass    = (pop && cmd_data.is_last) || (scan_done && (state == ST_REJ) && removed);

  // Memory write: loading in idle, compaction of survivors while rejecting.
  always_comb begin
    we    = 1'b0;
    waddr = kept[AW-1:0];
    wdata = rd;
    if (state == ST_IDLE) begin
      we    = pop && cmd_data.store;
      waddr = lcnt[AW-1:0];
      wdata = cmd_data.sample;
    end else if (state == ST_REJ) begin
      we = rv && !reject;
    end
  end

  // Sample memory with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd <= mem[raddr];
  end

  // Cutoff register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sigma <= SIGMA_RESET;
    end else if (cfg_we) begin
      sigma <= cfg_wdata;
    end
  end

  // Sequencer for loading, selection, threshold and rejection passes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lcnt      <= '0;
      rv        <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // Read issue during scans.
      if (scanning) begin
        rv <= issue;
        if (issue) begin
          cnt <= cnt + 1'b1;
        end
      end else begin
        rv <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (cmd_data.store) begin
              lcnt <= lcnt + 1'b1;
            end
            if (cmd_data.is_last) begin
              lcnt  <= '0;
              n_cur <= n_start;
              state <= ST_SEL;
            end
          end
        end
        ST_SEL: begin
          if (rv && match) begin
            c <= c + 1'b1;
          end
          if (scan_done) begin
            cnt <= '0;
            c   <= '0;
            if (sel_mask[0]) begin
              if (!phase_mad) begin
                med       <= {~prefix_next[31], prefix_next[30:0]};
                phase_mad <= 1'b1;
                prefix    <= '0;
                sel_mask  <= 32'h8000_0000;
                hi_mask   <= '0;
                k         <= rank_cur;
              end else begin
                mad   <= prefix_next;
                state <= ST_MUL;
              end
            end else begin
              prefix   <= prefix_next;
              k        <= bit_one ? (k - c) : k;
              sel_mask <= sel_mask >> 1;
              hi_mask  <= {1'b1, hi_mask[31:1]};
            end
          end
        end
        ST_MUL: begin
          thr     <= 48'(sigma) * 48'(mad);
          cnt     <= '0;
          kept    <= '0;
          removed <= 1'b0;
          state   <= ST_REJ;
        end
        ST_REJ: begin
          if (rv) begin
            if (reject) begin
              removed <= 1'b1;
            end else begin
              kept <= kept + 1'b1;
            end
          end
          if (scan_done) begin
            n_cur <= kept;
            state <= removed ? ST_SEL : ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_data.median     <= med;
            out_data.mad        <= mad;
            out_data.kept_count <= 11'(n_cur);
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Common setup for a fresh median pass.
      if (start_pass) begin
        cnt       <= '0;
        c         <= '0;
        k         <= rank_start;
        prefix    <= '0;
        sel_mask  <= 32'h8000_0000;
        hi_mask   <= '0;
        phase_mad <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scanning |-> cnt <= n_cur)
    else $error("scan index beyond set size");
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REJ) |-> kept <= cnt)
    else $error("survivor count ahead of scan");
  a_set_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEL) |-> n_cur != '0)
    else $error("selection on an empty set");
`endif

endmodule

`default_nettype wire

/* rtl/core/median_mad_outlier_rejection_unit.sv */
// Channel | Signals                        | Transfer when
// input   | in_valid, in_ready, in_data    | in_valid && in_ready
// output  | out_valid, out_ready, out_data | out_valid && out_ready
// config  | cfg_we, cfg_wdata              | cfg_we
//
// Loading runs at one sample per cycle while the short queue between front and back
// has room. Each pass runs 64 radix scans and one reject scan through the single memory
// read port, with a threshold step before the reject scan; passes repeat while samples
// are rejected, then the result is presented; the input stalls once the queue is full.
// Reset is synchronous and returns to an empty set with the cutoff at 6.0.
// A result waiting at the output does not stop loading of the next set.
`default_nettype none

module median_mad_outlier_rejection_unit #(
  parameter int unsigned MAX_SAMPLES = mmor_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned QUEUE_DEPTH = mmor_pkg::QUEUE_DEPTH_DEF
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  mmor_pkg::in_t   in_data,
  output logic            out_valid,
  input  wire             out_ready,
  output mmor_pkg::out_t  out_data,
  input  wire             cfg_we,
  input  wire [15:0]      cfg_wdata
);
  import mmor_pkg::*;

  logic f_valid;
  logic f_ready;
  cmd_t f_data;
  logic q_valid;
  logic q_ready;
  cmd_t q_data;

  mmor_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data)
  );

  mmor_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst,
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_data),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_data)
  );

  mmor_engine #(.MAX_SAMPLES(MAX_SAMPLES)) u_engine (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_data),
    .out_valid, .out_ready, .out_data
  );

endmodule

`default_nettype wire
